// File: design/ipss_pkg.sv
// ipss_pkg: types and constants shared by the integer pid speed step core
// no dependencies; imported by ipss_err_stage, the top level and the checker

package ipss_pkg;

    localparam int TARGET_W   = 16;
    localparam int ERR_W      = 17;
    localparam int DELTA_W    = 18;
    localparam int INTEG_W    = 8;
    localparam int GAIN_W     = 8;
    localparam int IPROD_W    = 16;
    localparam int DRIVE_W    = 12;
    localparam int S_DATA_W   = 32;
    localparam int M_DATA_W   = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic signed [INTEG_W-1:0] INTEG_MAX = 8'sd100;
    localparam logic signed [INTEG_W-1:0] INTEG_MIN = -8'sd100;
    localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 12'sd1999;
    localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = -12'sd1999;

    // ceil(2^16 / 10), exact quotient for magnitudes up to 12800
    localparam int          DIV10_SHIFT = 16;
    localparam logic [12:0] DIV10_RECIP = 13'd6554;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN  = 2'd0,
        REG_INT_GAIN   = 2'd1,
        REG_DERIV_GAIN = 2'd2
    } cfg_index_t;

    // first stage result handed to the drive stage
    typedef struct packed {
        logic [ERR_W-1:0]   err;
        logic [DELTA_W-1:0] delta;
        logic [IPROD_W-1:0] iprod;
    } ipss_stage_t;

endpackage

// File: design/integer_pid_speed_step_core.sv
// Integer PID speed step. Each item carries a target and a measured speed;
// one drive value comes back per item, saturated to -1999..1999. The core is
// a two-stage pipeline: the first stage forms the error, updates the clamped
// integral (-100..100) and the stored error, and multiplies the integral by
// int_gain; the second stage sums the proportional and integral/10 terms
// minus the derivative term and saturates into the output register. One
// item is taken per cycle while m_tready is held high and passes the stage
// and output registers before m_tvalid rises. Gains are written through
// the cfg channel (index 0 prop_gain, 1 int_gain, 2 deriv_gain, others
// ignored), all reset to zero; write them only while the pipeline is empty.
// depends on ipss_pkg and ipss_err_stage

module integer_pid_speed_step_core
    import ipss_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // target [15:0], measured [31:16]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // drive [11:0], zeros [15:12]
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [GAIN_W-1:0]    cfg_data
);

    localparam int PPROD_W = GAIN_W + ERR_W;
    localparam int DPROD_W = GAIN_W + DELTA_W;
    localparam int SUM_W   = DPROD_W + 1;
    localparam int ABS_W   = IPROD_W - 1;
    localparam int RECIP_W = ABS_W + 13;
    localparam int QUOT_W  = DRIVE_W - 1;

    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(DRIVE_MAX);
    localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(DRIVE_MIN);

    logic signed [GAIN_W-1:0] prop_gain_reg;
    logic signed [GAIN_W-1:0] int_gain_reg;
    logic signed [GAIN_W-1:0] deriv_gain_reg;

    logic                     st_valid_reg;
    logic                     m_valid_reg;
    logic [DRIVE_W-1:0]       drive_reg;
    logic [DRIVE_W-1:0]       drive_next;

    logic                     accept;
    logic                     advance;
    ipss_stage_t              stage;

    logic signed [PPROD_W-1:0] pterm;
    logic signed [DPROD_W-1:0] dterm;
    logic [IPROD_W-1:0]        iabs;
    logic [RECIP_W-1:0]        recip;
    logic [QUOT_W-1:0]         quot;
    logic signed [DRIVE_W-1:0] iterm;
    logic signed [SUM_W-1:0]   total;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg  <= '0;
            int_gain_reg   <= '0;
            deriv_gain_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_PROP_GAIN:  prop_gain_reg  <= cfg_data;
                REG_INT_GAIN:   int_gain_reg   <= cfg_data;
                REG_DERIV_GAIN: deriv_gain_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline control
    assign advance  = st_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !st_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                st_valid_reg <= 1'b1;
            end else if (advance) begin
                st_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    ipss_err_stage u_err_stage (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept),
        .target   (s_tdata[TARGET_W-1:0]),
        .measured (s_tdata[2*TARGET_W-1:TARGET_W]),
        .int_gain (int_gain_reg),
        .stage    (stage)
    );

    // drive stage
    assign pterm = prop_gain_reg * $signed(stage.err);
    assign dterm = deriv_gain_reg * $signed(stage.delta);

    // integral term divided by ten, truncated toward zero
    assign iabs  = stage.iprod[IPROD_W-1] ? (~stage.iprod + 1'b1) : stage.iprod;
    assign recip = {13'd0, iabs[ABS_W-1:0]} * {{ABS_W{1'b0}}, DIV10_RECIP};
    assign quot  = recip[DIV10_SHIFT +: QUOT_W];
    assign iterm = stage.iprod[IPROD_W-1] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

    assign total = SUM_W'(pterm) + SUM_W'(iterm) - SUM_W'(dterm);

    always_comb begin
        if (total >= SUM_MAX) begin
            drive_next = DRIVE_MAX;
        end else if (total <= SUM_MIN) begin
            drive_next = DRIVE_MIN;
        end else begin
            drive_next = total[DRIVE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            drive_reg <= drive_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W-DRIVE_W){1'b0}}, drive_reg};

endmodule

// File: design/ipss_err_stage.sv
// ipss_err_stage: error, clamped integral, error change and integral product
// holds the controller state; uses ipss_pkg

module ipss_err_stage
    import ipss_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     load,
    input  logic signed [TARGET_W-1:0] target,
    input  logic signed [TARGET_W-1:0] measured,
    input  logic signed [GAIN_W-1:0] int_gain,
    output ipss_stage_t              stage
);

    logic signed [ERR_W-1:0]   prev_error_reg;
    logic signed [INTEG_W-1:0] integral_reg;
    ipss_stage_t               stage_reg;

    logic signed [ERR_W-1:0]   err;
    logic signed [DELTA_W-1:0] sum;
    logic signed [INTEG_W-1:0] integral_next;
    logic signed [IPROD_W-1:0] iprod;
    logic signed [DELTA_W-1:0] delta;

    assign err   = ERR_W'(target) - ERR_W'(measured);
    assign sum   = DELTA_W'(integral_reg) + DELTA_W'(err);
    assign delta = DELTA_W'(err) - DELTA_W'(prev_error_reg);

    always_comb begin
        if (sum > DELTA_W'(INTEG_MAX)) begin
            integral_next = INTEG_MAX;
        end else if (sum < DELTA_W'(INTEG_MIN)) begin
            integral_next = INTEG_MIN;
        end else begin
            integral_next = sum[INTEG_W-1:0];
        end
    end

    assign iprod = int_gain * integral_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_error_reg <= '0;
            integral_reg   <= '0;
        end else if (load) begin
            prev_error_reg <= err;
            integral_reg   <= integral_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            stage_reg.err   <= err;
            stage_reg.delta <= delta;
            stage_reg.iprod <= iprod;
        end
    end

    assign stage = stage_reg;

endmodule

// File: design/ipss_checker.sv
// ipss_checker: port-level assertions for integer_pid_speed_step_core
// uses ipss_pkg; bound to the top level below

module ipss_checker
    import ipss_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_DATA_W-1:0]  m_tdata,
    input logic                 cfg_valid,
    input logic                 cfg_ready
);

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // drive stays inside the saturation limits, pad bits zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[DRIVE_W-1:0]) >= DRIVE_MIN)
                  && ($signed(m_tdata[DRIVE_W-1:0]) <= DRIVE_MAX)
                  && (m_tdata[M_DATA_W-1:DRIVE_W] == '0))
        else $error("drive out of range");

    // no result right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // an empty pipeline always takes an item
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !m_tvalid && $past(!s_tvalid) && $past(!m_tvalid) |-> s_tready)
        else $error("idle core not ready");

    // configuration is never stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("cfg write stalled");

endmodule

bind integer_pid_speed_step_core ipss_checker u_ipss_checker (.*);
